FILE: src/tcpopr_pkg.sv
package tcpopr_pkg;

    // replacement bytes held in the target value registers
    localparam int TGT_BYTES       = 36;
    // rewrite limit per option
    localparam int MAX_VALUE_BYTES = 36;

    localparam logic [7:0] KIND_EOL   = 8'd0;
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_TOA_A = 8'd253;
    localparam logic [7:0] KIND_TOA_B = 8'd254;
    localparam logic [7:0] TOA_LEN    = 8'd8;
    localparam logic [7:0] LEN_UNKNOWN = 8'd0;
    localparam logic [7:0] LEN_ANY     = 8'd255;
    localparam logic [7:0] LEN_MIN     = 8'd2;

    typedef enum logic [1:0] {
        ROLE_KIND  = 2'd0,
        ROLE_LEN   = 2'd1,
        ROLE_VALUE = 2'd2,
        ROLE_NONE  = 2'd3
    } t_role;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EOL      = 3'd1,
        ST_BADLEN   = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_MISMATCH = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_KIND = 3'd0,
        REG_LEN  = 3'd1,
        REG_W0   = 3'd2,
        REG_W1   = 3'd3,
        REG_W2   = 3'd4,
        REG_W3   = 3'd5,
        REG_W4   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]                 kind;
        logic [5:0]                 len;
        logic [TGT_BYTES-1:0][7:0]  value;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      role;
        logic       done;
        logic [7:0] kind;
        t_status    status;
        logic       rewritten;
    } t_result;

    function automatic logic [7:0] expected_length(input logic [7:0] kind);
        logic [7:0] len;
        case (kind)
            8'd2:                       len = 8'd4;
            8'd3:                       len = 8'd3;
            8'd4:                       len = 8'd2;
            8'd6, 8'd7:                 len = 8'd6;
            8'd8:                       len = 8'd10;
            8'd9:                       len = 8'd2;
            8'd10, 8'd14, 8'd18:        len = 8'd3;
            8'd19:                      len = 8'd18;
            8'd27:                      len = 8'd8;
            8'd28:                      len = 8'd4;
            8'd5, 8'd15, 8'd30, 8'd34,
            8'd69, 8'd172, 8'd174:      len = LEN_ANY;
            8'd253, 8'd254:             len = 8'd8;
            default:                    len = LEN_UNKNOWN;
        endcase
        return len;
    endfunction

    function automatic logic is_toa(input logic [7:0] kind, input logic [7:0] len);
        return ((kind == KIND_TOA_A) || (kind == KIND_TOA_B)) && (len == TOA_LEN);
    endfunction

endpackage

FILE: src/tcpopr_cfg.sv
module tcpopr_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output tcpopr_pkg::t_cfg    o_cfg
);

    logic [7:0]  r_kind;
    logic [5:0]  r_len;
    logic [63:0] r_w0, r_w1, r_w2, r_w3;
    logic [31:0] r_w4;
    logic        w_wr;
    tcpopr_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = tcpopr_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= '0;
            r_len  <= '0;
            r_w0   <= '0;
            r_w1   <= '0;
            r_w2   <= '0;
            r_w3   <= '0;
            r_w4   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                tcpopr_pkg::REG_KIND: r_kind <= pwdata[7:0];
                tcpopr_pkg::REG_LEN:  r_len  <= pwdata[5:0];
                tcpopr_pkg::REG_W0:   r_w0   <= pwdata;
                tcpopr_pkg::REG_W1:   r_w1   <= pwdata;
                tcpopr_pkg::REG_W2:   r_w2   <= pwdata;
                tcpopr_pkg::REG_W3:   r_w3   <= pwdata;
                tcpopr_pkg::REG_W4:   r_w4   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tcpopr_pkg::REG_KIND: prdata = {56'd0, r_kind};
            tcpopr_pkg::REG_LEN:  prdata = {58'd0, r_len};
            tcpopr_pkg::REG_W0:   prdata = r_w0;
            tcpopr_pkg::REG_W1:   prdata = r_w1;
            tcpopr_pkg::REG_W2:   prdata = r_w2;
            tcpopr_pkg::REG_W3:   prdata = r_w3;
            tcpopr_pkg::REG_W4:   prdata = {32'd0, r_w4};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.kind  = r_kind;
    assign o_cfg.len   = r_len;
    assign o_cfg.value = {r_w4, r_w3, r_w2, r_w1, r_w0};

endmodule

FILE: src/tcpopr_core.sv
module tcpopr_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  tcpopr_pkg::t_cfg        i_cfg,
    output tcpopr_pkg::t_result     o_res
);

    typedef enum logic [2:0] {
        PH_KIND  = 3'b001,
        PH_LEN   = 3'b010,
        PH_VALUE = 3'b100
    } t_phase;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_kind,    n_kind;
    logic [7:0] r_length,  n_length;
    logic [7:0] r_pos,     n_pos;
    tcpopr_pkg::t_status r_status, n_status;
    logic       r_stopped, n_stopped;

    logic [7:0] w_exp;
    logic [7:0] w_vlen;
    logic [8:0] w_pos_inc;
    tcpopr_pkg::t_status w_len_st;
    logic       w_rw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_KIND;
            r_kind    <= '0;
            r_length  <= '0;
            r_pos     <= '0;
            r_status  <= tcpopr_pkg::ST_OK;
            r_stopped <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_length  <= n_length;
            r_pos     <= n_pos;
            r_status  <= n_status;
            r_stopped <= n_stopped;
        end
    end

    // length byte classification against the expected-length table
    always_comb begin
        w_exp = tcpopr_pkg::expected_length(r_kind);
        if (tcpopr_pkg::is_toa(r_kind, i_byte))
            w_len_st = tcpopr_pkg::ST_OK;
        else if (w_exp == tcpopr_pkg::LEN_UNKNOWN)
            w_len_st = tcpopr_pkg::ST_UNKNOWN;
        else if ((w_exp != tcpopr_pkg::LEN_ANY) && (w_exp != i_byte))
            w_len_st = tcpopr_pkg::ST_MISMATCH;
        else
            w_len_st = tcpopr_pkg::ST_OK;
    end

    assign w_vlen    = r_length - tcpopr_pkg::LEN_MIN;
    assign w_pos_inc = {1'b0, r_pos} + 9'd1;
    assign w_rw      = (r_kind == i_cfg.kind) && !tcpopr_pkg::is_toa(r_kind, r_length)
                     && (r_pos < 8'(tcpopr_pkg::MAX_VALUE_BYTES))
                     && (r_pos < {2'b00, i_cfg.len}) && (r_pos < w_vlen);

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_length  = r_length;
        n_pos     = r_pos;
        n_status  = r_status;
        n_stopped = r_stopped;

        o_res.out_byte  = i_byte;
        o_res.role      = tcpopr_pkg::ROLE_NONE;
        o_res.done      = 1'b0;
        o_res.kind      = '0;
        o_res.status    = tcpopr_pkg::ST_OK;
        o_res.rewritten = 1'b0;

        if (!r_stopped) begin
            case (r_phase)
                PH_KIND: begin
                    o_res.role = tcpopr_pkg::ROLE_KIND;
                    o_res.kind = i_byte;
                    if (i_byte == tcpopr_pkg::KIND_EOL) begin
                        o_res.done   = 1'b1;
                        o_res.status = tcpopr_pkg::ST_EOL;
                        n_stopped    = 1'b1;
                    end else if (i_byte == tcpopr_pkg::KIND_NOP) begin
                        o_res.done = 1'b1;
                    end else begin
                        n_kind = i_byte;
                        if (i_last) begin
                            o_res.done   = 1'b1;
                            o_res.status = tcpopr_pkg::ST_TRUNC;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    o_res.role = tcpopr_pkg::ROLE_LEN;
                    o_res.kind = r_kind;
                    if (i_byte < tcpopr_pkg::LEN_MIN) begin
                        o_res.done   = 1'b1;
                        o_res.status = tcpopr_pkg::ST_BADLEN;
                        n_stopped    = 1'b1;
                        n_phase      = PH_KIND;
                    end else begin
                        o_res.status = w_len_st;
                        n_status     = w_len_st;
                        n_length     = i_byte;
                        if (i_byte == tcpopr_pkg::LEN_MIN) begin
                            o_res.done = 1'b1;
                            n_phase    = PH_KIND;
                        end else if (i_last) begin
                            o_res.done   = 1'b1;
                            o_res.status = tcpopr_pkg::ST_TRUNC;
                        end else begin
                            n_pos   = '0;
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    o_res.role   = tcpopr_pkg::ROLE_VALUE;
                    o_res.kind   = r_kind;
                    o_res.status = r_status;
                    if (w_rw) begin
                        o_res.rewritten = 1'b1;
                        // replacement bytes past the register bank read as zero
                        o_res.out_byte  = (r_pos < 8'(tcpopr_pkg::TGT_BYTES))
                                        ? i_cfg.value[r_pos[5:0]] : 8'd0;
                    end
                    if (w_pos_inc >= {1'b0, w_vlen}) begin
                        o_res.done = 1'b1;
                        n_phase    = PH_KIND;
                        n_pos      = '0;
                    end else begin
                        n_pos = w_pos_inc[7:0];
                        if (i_last) begin
                            o_res.done   = 1'b1;
                            o_res.status = tcpopr_pkg::ST_TRUNC;
                        end
                    end
                end
                default: begin
                    n_phase = PH_KIND;
                end
            endcase
        end

        // end of option area restarts the parser
        if (i_last) begin
            n_phase   = PH_KIND;
            n_pos     = '0;
            n_stopped = 1'b0;
        end
    end

endmodule

FILE: src/tcp_option_parse_rewrite.sv
// a taken byte goes through the input register, the combinational parse step
// and the result register that drives the outputs; throughput: one option
// byte per cycle while i_stall does not hold the result register
// reset (synchronous, active low): parser back to expect-kind, not stopped,
// all target registers cleared, both holding registers empty
module tcp_option_parse_rewrite (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_byte_role,
    output logic        o_option_done,
    output logic [7:0]  o_option_kind,
    output logic [2:0]  o_option_status,
    output logic        o_rewritten,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic                   r_out_valid;
    tcpopr_pkg::t_result    r_out;
    tcpopr_pkg::t_result    w_res;
    tcpopr_pkg::t_cfg       w_cfg;
    logic                   w_out_load;
    logic                   w_fire;
    logic                   w_in_acc;

    tcpopr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_load = !r_out_valid || !i_stall;
    assign w_fire     = r_in_valid && w_out_load;
    assign o_stall    = r_in_valid && !w_out_load;
    assign w_in_acc   = i_valid && !o_stall;

    tcpopr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out.out_byte;
    assign o_byte_role     = r_out.role;
    assign o_option_done   = r_out.done;
    assign o_option_kind   = r_out.kind;
    assign o_option_status = r_out.status;
    assign o_rewritten     = r_out.rewritten;

    a_unparsed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_byte_role == tcpopr_pkg::ROLE_NONE)
        |-> !o_option_done && !o_rewritten && (o_option_kind == 8'd0)
            && (o_option_status == tcpopr_pkg::ST_OK))
        else $error("unparsed byte carries option info");

    a_rewrite_value_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rewritten |-> (o_byte_role == tcpopr_pkg::ROLE_VALUE))
        else $error("rewrite on a non-value byte");

    a_eol_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_option_status == tcpopr_pkg::ST_EOL)
        |-> o_option_done && (o_byte_role == tcpopr_pkg::ROLE_KIND)
            && (o_option_kind == tcpopr_pkg::KIND_EOL))
        else $error("end of list reported on wrong byte");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_stall |-> o_stall)
        else $error("input taken while both stages are held");

endmodule
